@@ hw/rtl/tep_pkg.sv @@
// Package of the tuning edit frame parser: frame constants, parse phase codes,
// event codes, register indexes and the shared struct types.
// No dependencies.
`default_nettype none

package tep_pkg;

   localparam int PAGE_COUNT = 5;

   localparam int PAGE_W   = 3;
   localparam int COUNT_W  = 8;
   localparam int BYTE_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int BODY_LEN = 7;
   localparam int BODY_STORE = BODY_LEN - 1;
   localparam int BODY_CNT_W = 3;
   localparam int BODY_IDX_W = $clog2(BODY_STORE);

   localparam logic [4:0] PAGE_LIMIT = 5'(PAGE_COUNT);

   localparam logic [BYTE_W-1:0] HDR_A       = 8'h52;
   localparam logic [BYTE_W-1:0] HDR_B       = 8'h14;
   localparam logic [BYTE_W-1:0] HDR_C       = 8'h88;
   localparam logic [BYTE_W-1:0] SEL_BODY    = 8'h01;
   localparam logic [BYTE_W-1:0] SEL_END     = 8'h77;
   localparam logic [BYTE_W-1:0] TRL_INT_LO  = 8'h31;
   localparam logic [BYTE_W-1:0] TRL_INT_HI  = 8'h40;
   localparam logic [BYTE_W-1:0] TRL_FLT_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] TRL_FLT_HI  = 8'h00;

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   localparam logic [KIND_W-1:0] EV_INT    = 2'd0;
   localparam logic [KIND_W-1:0] EV_FLOAT  = 2'd1;
   localparam logic [KIND_W-1:0] EV_END    = 2'd2;
   localparam logic [KIND_W-1:0] EV_REJECT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PAGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOAT_COUNT = 2'd2;

   typedef struct packed {
      logic [PAGE_W-1:0]  active_page;
      logic [COUNT_W-1:0] int_entry_count;
      logic [COUNT_W-1:0] float_entry_count;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } in_word_type;

endpackage

`default_nettype wire

@@ hw/rtl/tep_if.sv @@
// Channel interfaces of the tuning edit frame parser: the byte request
// channel and the result channel. Depends on tep_pkg.
`default_nettype none

interface tep_req_if;
   logic                      valid;
   logic                      ready;
   logic [tep_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tep_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tep_pkg::KIND_W-1:0]  event_kind;
   logic [tep_pkg::PAGE_W-1:0]  target_page;
   logic [tep_pkg::BYTE_W-1:0]  entry_index;
   logic [tep_pkg::VALUE_W-1:0] entry_value;

   modport source (output valid, output event_kind, output target_page,
                   output entry_index, output entry_value, input ready);
   modport sink (input valid, input event_kind, input target_page,
                 input entry_index, input entry_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tep_csr.sv @@
// Configuration registers of the tuning edit frame parser, written through a
// plain write port. Depends on tep_pkg.
`default_nettype none

module tep_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [tep_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tep_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tep_pkg::cfg_type                     cfg
);

   tep_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tep_pkg::CSR_ACTIVE_PAGE: cfg_in.active_page = csr_wdata[tep_pkg::PAGE_W-1:0];
            tep_pkg::CSR_INT_COUNT:   cfg_in.int_entry_count = csr_wdata;
            tep_pkg::CSR_FLOAT_COUNT: cfg_in.float_entry_count = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tep_in_stage.sv @@
// Input register of the tuning edit frame parser: holds one received word
// until the parser takes it. Depends on tep_pkg and tep_if.
`default_nettype none

module tep_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   tep_req_if.sink              req_bus,
   input  wire logic            take,
   output tep_pkg::in_word_type word_out
);

   logic                       valid_ff, valid_in;
   logic [tep_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       load;

   assign req_bus.ready = !valid_ff || take;
   assign load = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in = req_bus.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word_out.valid = valid_ff;
   assign word_out.rx_byte = byte_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tep_parser.sv @@
// Frame parse state machine and result register of the tuning edit frame
// parser. Depends on tep_pkg and tep_if.
`default_nettype none

module tep_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tep_pkg::in_word_type word_in,
   input  wire tep_pkg::cfg_type     cfg,
   output logic                      take,
   tep_rsp_if.source                 rsp_bus
);

   logic [1:0]                           phase_ff, phase_in;
   logic [tep_pkg::BODY_CNT_W-1:0]       count_ff, count_in;
   logic [tep_pkg::BYTE_W-1:0]           body_ff [tep_pkg::BODY_STORE];
   logic                                 body_wr;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tep_pkg::KIND_W-1:0]           kind_ff, kind_in;
   logic [tep_pkg::PAGE_W-1:0]           page_ff;
   logic [tep_pkg::BYTE_W-1:0]           index_ff, index_in;
   logic [tep_pkg::VALUE_W-1:0]          value_ff, value_in;
   logic                                 advance, fire, emit;
   logic                                 is_hdr, is_int, is_float, bad_index;
   logic [tep_pkg::BYTE_W-1:0]           b;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign take = word_in.valid && advance;
   assign fire = take;
   assign b = word_in.rx_byte;

   assign is_hdr = (b == tep_pkg::HDR_A) || (b == tep_pkg::HDR_B) || (b == tep_pkg::HDR_C);
   assign is_int = (body_ff[tep_pkg::BODY_STORE-1] == tep_pkg::TRL_INT_LO)
                   && (b == tep_pkg::TRL_INT_HI);
   assign is_float = (body_ff[tep_pkg::BODY_STORE-1] == tep_pkg::TRL_FLT_LO)
                     && (b == tep_pkg::TRL_FLT_HI);
   assign bad_index = (is_int && (body_ff[0] >= cfg.int_entry_count))
                      || (is_float && (body_ff[0] >= cfg.float_entry_count))
                      || ({2'b00, cfg.active_page} >= tep_pkg::PAGE_LIMIT);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      body_wr = 1'b0;
      emit = 1'b0;
      kind_in = tep_pkg::EV_END;
      index_in = '0;
      value_in = '0;
      if (fire) begin
         unique case (phase_ff)
            tep_pkg::PH_HUNT: begin
               if (is_hdr) begin
                  phase_in = tep_pkg::PH_SECOND;
               end
            end
            tep_pkg::PH_SECOND: begin
               if (b == tep_pkg::SEL_BODY) begin
                  phase_in = tep_pkg::PH_BODY;
                  count_in = '0;
               end else begin
                  phase_in = tep_pkg::PH_HUNT;
                  emit = (b == tep_pkg::SEL_END);
               end
            end
            tep_pkg::PH_BODY: begin
               if (count_ff == tep_pkg::BODY_CNT_W'(tep_pkg::BODY_STORE)) begin
                  phase_in = tep_pkg::PH_HUNT;
                  count_in = '0;
                  emit = is_int || is_float;
                  kind_in = bad_index ? tep_pkg::EV_REJECT
                          : (is_int ? tep_pkg::EV_INT : tep_pkg::EV_FLOAT);
                  index_in = body_ff[0];
                  value_in = {body_ff[4], body_ff[3], body_ff[2], body_ff[1]};
               end else begin
                  body_wr = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               phase_in = tep_pkg::PH_HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tep_pkg::PH_HUNT;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (body_wr) begin
         body_ff[count_ff[tep_pkg::BODY_IDX_W-1:0]] <= b;
      end
      if (emit) begin
         kind_ff <= kind_in;
         page_ff <= cfg.active_page;
         index_ff <= index_in;
         value_ff <= value_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.event_kind = kind_ff;
   assign rsp_bus.target_page = page_ff;
   assign rsp_bus.entry_index = index_ff;
   assign rsp_bus.entry_value = value_ff;

`ifndef SYNTH
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != tep_pkg::PH_BODY |-> count_ff == '0)
      else $error("body count nonzero outside body phase");

   a_end_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == tep_pkg::EV_END |-> index_ff == '0 && value_ff == '0)
      else $error("session end word carries index or value");

   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(word_in.valid))
      else $error("result word without an input word");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(count_ff))
      else $error("parse state moved while the result was stalled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tuning_edit_frame_parser.sv @@
// Top level of the tuning edit frame parser: input register, parse state
// machine with result register, and configuration registers.
// Depends on tep_pkg, tep_if, tep_csr, tep_in_stage and tep_parser.
//
//   channel   direction  handshake          word
//   req_bus   in         valid/ready        rx_byte[7:0]
//   rsp_bus   out        valid/ready        event_kind, target_page, entry_index, entry_value
//   csr_*     in         csr_wr_en only     csr_index[1:0], csr_wdata[7:0]
//
// One word is accepted every cycle while the result side keeps up; a byte
// goes through the input register and then the parse state machine, whose
// result register holds the result once the last byte of its frame is parsed.
// Synchronous active-high reset clears the parse state, valid flags and config registers.
// A stalled result holds the parser and fills the input register, then
// req_bus.ready drops.
`default_nettype none

module tuning_edit_frame_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tep_req_if.sink                             req_bus,
   tep_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [tep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tep_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tep_pkg::cfg_type     cfg;
   tep_pkg::in_word_type in_word;
   logic                 take;

   tep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tep_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .take     (take),
      .word_out (in_word)
   );

   tep_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .word_in (in_word),
      .cfg     (cfg),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
